// ===== rtl/sirb_pkg.sv =====
// Shared types and constants of the sequence indexed ring buffer.
// No dependencies; every other file but sirb_chan_if imports this package.
package sirb_pkg;

  localparam int DEFAULT_DEPTH        = 4096;
  localparam int DEFAULT_MAX_READ_RUN = 64;

  localparam logic [12:0] CAPACITY_RESET = 13'd4096;
  localparam logic [15:0] START_RESET    = 16'd0;

  localparam logic [2:0] MODE_WRITE     = 3'd0;
  localparam logic [2:0] MODE_READ      = 3'd1;
  localparam logic [2:0] MODE_SET_WRITE = 3'd2;
  localparam logic [2:0] MODE_SET_READ  = 3'd3;
  localparam logic [2:0] MODE_SET_KEPT  = 3'd4;
  localparam logic [2:0] MODE_QUERY     = 3'd5;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_START    = 2'd1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] position;
    logic [12:0] length;
    logic [11:0] offset;
    logic [7:0]  data_in;
    logic        commit;
    logic        retain;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  data_out;
    logic [15:0] amount;
    logic [15:0] used;
    logic [15:0] free_space;
    logic [15:0] readable;
    logic [15:0] last_written;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] value;
  } cfg_write_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_EXEC,
    ST_RD_MEM,
    ST_RD_OUT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic mod_start;
    logic exec;
    logic rd_start;
    logic mem_rd;
    logic rd_emit;
    logic clr_write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_mod;
    logic is_read;
    logic n_zero;
    logic mod_done;
    logic out_free;
    logic rd_last;
    logic clr_done;
  } dp_status_t;

endpackage

// ===== rtl/sirb_chan_if.sv =====
// Valid/ready channel carrying one payload of type T.
// No dependencies.
interface sirb_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sequence_indexed_ring_buffer.sv =====
// Top level of the sequence indexed ring buffer.
// Depends on sirb_pkg, sirb_chan_if, sirb_ctrl and sirb_dpath.
//
// Byte ring buffer addressed by 16-bit sequence positions with kept, read and
// write pointers. After reset the byte store is cleared one slot per cycle; no
// item is taken while it clears (configuration writes still are). A write
// byte's slot is computed by a bit-serial remainder unit. A read computes its
// first slot the same way and then emits its bytes one at a time, each fetched
// through the registered read port of the byte store. Items are handled one at
// a time; the next item is taken while the last result still waits in the
// output register. The configuration channel is always ready; write it only
// while the block is idle.
module sequence_indexed_ring_buffer
  import sirb_pkg::*;
#(
  parameter int DEPTH        = DEFAULT_DEPTH,
  parameter int MAX_READ_RUN = DEFAULT_MAX_READ_RUN
) (
  input logic      clk,
  input logic      rst,
  sirb_chan_if.sink   req,
  sirb_chan_if.source rsp,
  sirb_chan_if.sink   cfg
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // configuration registers accept a transfer on any cycle
  assign cfg.ready = 1'b1;

  sirb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sirb_dpath #(
    .DEPTH        (DEPTH),
    .MAX_READ_RUN (MAX_READ_RUN)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (req.data),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp.data)
  );

endmodule

// ===== rtl/sirb_mod.sv =====
// Restoring remainder unit: 16-bit dividend mod 13-bit divisor, one bit per cycle.
// Depends on sirb_pkg.
module sirb_mod
  import sirb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [12:0] divisor,
  output logic        done,
  output logic [12:0] rem
);

  logic        busy;
  logic [3:0]  cnt;
  logic [15:0] dvd;
  logic [13:0] part;
  logic [12:0] dsr;
  logic [13:0] trial;

  assign trial = {part[12:0], dvd[15]};
  assign rem   = part[12:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      dvd  <= dividend;
      dsr  <= divisor;
      part <= '0;
    end else if (busy) begin
      // shift in one dividend bit, subtract when it fits
      part <= (trial >= {1'b0, dsr}) ? trial - {1'b0, dsr} : trial;
      dvd  <= {dvd[14:0], 1'b0};
      cnt  <= cnt + 4'd1;
      if (cnt == 4'd15) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/sirb_dpath.sv =====
// Datapath: pointers, configuration, byte store, remainder unit and output register.
// Depends on sirb_pkg and sirb_mod.
module sirb_dpath
  import sirb_pkg::*;
#(
  parameter int DEPTH        = DEFAULT_DEPTH,
  parameter int MAX_READ_RUN = DEFAULT_MAX_READ_RUN
) (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   in_data,
  input  logic       cfg_valid,
  input  cfg_write_t cfg_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t sts,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(MAX_READ_RUN + 1);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data;
  logic [12:0]   capacity;
  logic [15:0]   start_pos;
  logic [15:0]   write_ptr, read_ptr, kept_ptr;
  logic [15:0]   write_ptr_next, read_ptr_next, kept_ptr_next;
  in_item_t      item;
  logic [AW-1:0] cursor;
  logic [15:0]   rd_pos;
  logic [AW-1:0] clr_addr;
  logic [NW-1:0] kcnt, nrun, n;
  logic [12:0]   ecap;
  logic [15:0]   readable_now, n_wide, nw;
  logic signed [18:0] win, nwd, swd, cap_s;
  logic          wok, op_status;
  logic [15:0]   amt;
  logic          mod_done;
  logic [12:0]   mod_rem;
  logic [15:0]   mod_dividend;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [15:0]   used_n;
  out_item_t     res;

  always_comb begin
    if (capacity == 13'd0) ecap = 13'd1;
    else if ({4'b0, capacity} > 17'(DEPTH)) ecap = 13'(DEPTH);
    else ecap = capacity;
  end

  assign mod_dividend = (in_data.mode == MODE_WRITE) ?
                        in_data.position + 16'(in_data.offset) : read_ptr;

  sirb_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (mod_dividend),
    .divisor  (ecap),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // read count: smallest of request, readable bytes and run limit
  assign readable_now = write_ptr - read_ptr;
  always_comb begin
    n_wide = {3'b0, item.length};
    if (readable_now < n_wide) n_wide = readable_now;
    if (n_wide > 16'(MAX_READ_RUN)) n_wide = 16'(MAX_READ_RUN);
  end
  assign n = NW'(n_wide);

  assign cap_s = $signed({6'b0, ecap});
  assign win   = $signed({3'b0, item.position}) - $signed({3'b0, kept_ptr})
               + $signed({6'b0, item.length});
  assign wok   = ({1'b0, item.offset} < item.length) && (item.position >= write_ptr)
               && (win <= cap_s);
  assign nw    = item.position + {3'b0, item.length};
  assign nwd   = $signed({3'b0, nw}) - $signed({3'b0, kept_ptr});
  assign swd   = $signed({3'b0, item.position}) - $signed({3'b0, kept_ptr});

  always_comb begin
    write_ptr_next = write_ptr;
    read_ptr_next  = read_ptr;
    kept_ptr_next  = kept_ptr;
    op_status      = 1'b1;
    amt            = '0;
    if (cmd.exec) begin
      unique case (item.mode)
        MODE_WRITE: begin
          amt = {15'b0, wok};
          if (wok) begin
            op_status = 1'b0;
            if (item.commit && ({1'b0, item.offset} == item.length - 13'd1)) begin
              if ((nw < write_ptr) || (nwd > cap_s)) op_status = 1'b1;
              else write_ptr_next = nw;
            end
          end
        end
        MODE_READ: op_status = 1'b0;
        MODE_SET_WRITE: begin
          if (!(item.position < write_ptr) && !(swd > cap_s)) begin
            write_ptr_next = item.position;
            op_status      = 1'b0;
          end
          amt = write_ptr_next;
        end
        MODE_SET_READ: begin
          if (!(item.position < kept_ptr) && !(item.position > write_ptr)) begin
            read_ptr_next = item.position;
            op_status     = 1'b0;
          end
          amt = read_ptr_next;
        end
        MODE_SET_KEPT: begin
          if (!(item.position > write_ptr)) begin
            kept_ptr_next = item.position;
            if (read_ptr < item.position) read_ptr_next = item.position;
            op_status = 1'b0;
          end
          amt = kept_ptr_next;
        end
        MODE_QUERY: op_status = 1'b0;
        default: op_status = 1'b1;
      endcase
    end
    if (cmd.rd_start) begin
      read_ptr_next = read_ptr + 16'(n);
      if (!item.retain) kept_ptr_next = kept_ptr + 16'(n);
    end
  end

  // occupancy figures reflect pointers after the item
  assign used_n = write_ptr_next - kept_ptr_next;
  always_comb begin
    res.status       = cmd.rd_emit ? 1'b0 : op_status;
    res.data_out     = cmd.rd_emit ? rd_data : 8'd0;
    res.amount       = cmd.rd_emit ? 16'(nrun) : amt;
    res.used         = used_n;
    res.free_space   = 16'(ecap) - used_n;
    res.readable     = write_ptr_next - read_ptr_next;
    res.last_written = write_ptr_next - 16'd1;
    res.last         = cmd.rd_emit ? sts.rd_last : 1'b1;
  end

  assign mem_we    = cmd.clr_write || (cmd.exec && (item.mode == MODE_WRITE) && wok);
  assign mem_waddr = cmd.clr_write ? clr_addr : AW'(mod_rem);
  assign mem_wdata = cmd.clr_write ? 8'd0 : item.data_in;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.mem_rd) rd_data <= mem[cursor];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAPACITY_RESET;
      start_pos <= START_RESET;
      write_ptr <= START_RESET;
      read_ptr  <= START_RESET;
      kept_ptr  <= START_RESET;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_data.index == REG_CAPACITY)) begin
        capacity  <= cfg_data.value[12:0];
        write_ptr <= start_pos;
        read_ptr  <= start_pos;
        kept_ptr  <= start_pos;
      end else if (cfg_valid && (cfg_data.index == REG_START)) begin
        start_pos <= cfg_data.value;
        write_ptr <= cfg_data.value;
        read_ptr  <= cfg_data.value;
        kept_ptr  <= cfg_data.value;
      end else begin
        write_ptr <= write_ptr_next;
        read_ptr  <= read_ptr_next;
        kept_ptr  <= kept_ptr_next;
      end
      if (cmd.clr_write) clr_addr <= clr_addr + AW'(1);
      if (cmd.exec || cmd.rd_emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= in_data;
    if (cmd.exec || cmd.rd_emit) out_data <= res;
    if (cmd.rd_start) begin
      cursor <= AW'(mod_rem);
      rd_pos <= read_ptr;
      kcnt   <= '0;
      nrun   <= n;
    end else if (cmd.rd_emit) begin
      // restart the slot at zero on a capacity wrap or when the position wraps to zero
      cursor <= ((rd_pos == 16'hFFFF) || ((17'(cursor) + 17'd1) == 17'(ecap))) ?
                '0 : cursor + AW'(1);
      rd_pos <= rd_pos + 16'd1;
      kcnt   <= kcnt + NW'(1);
    end
  end

  always_comb begin
    sts.need_mod = (in_data.mode == MODE_WRITE) || (in_data.mode == MODE_READ);
    sts.is_read  = (item.mode == MODE_READ);
    sts.n_zero   = (n == '0);
    sts.mod_done = mod_done;
    sts.out_free = !out_valid || out_ready;
    sts.rd_last  = (kcnt == nrun - NW'(1));
    sts.clr_done = (clr_addr == AW'(DEPTH - 1));
  end

endmodule

// ===== rtl/sirb_ctrl.sv =====
// Controller state machine: sequences clear, accept, remainder wait, execute and reads.
// Depends on sirb_pkg.
module sirb_ctrl
  import sirb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (sts.need_mod) begin
            cmd.mod_start = 1'b1;
            state_next    = ST_MOD;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_MOD: begin
        if (sts.mod_done) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.is_read && !sts.n_zero) begin
          cmd.rd_start = 1'b1;
          state_next   = ST_RD_MEM;
        end else if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_RD_MEM: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (sts.out_free) begin
          cmd.rd_emit = 1'b1;
          state_next  = sts.rd_last ? ST_IDLE : ST_RD_MEM;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
